FILE: rtl/core/dti_pkg.sv
// dti_pkg: shared types and constants of the decision tree inference block
// word layouts, item codes, result codes, controller/datapath command bundles
// no dependencies
package dti_pkg;

  localparam int IN_TDATA_W  = 144;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  // item kinds carried on in_tuser
  localparam logic [1:0] ACT_WRITE_NODE   = 2'd0;
  localparam logic [1:0] ACT_LOAD_FEATURE = 2'd1;
  localparam logic [1:0] ACT_CLASSIFY     = 2'd2;

  // result status codes carried on out_tuser
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_TREE = 2'd1;
  localparam logic [1:0] ST_DEPTH   = 2'd2;

  // input word, last field in the lowest bits
  typedef struct packed {
    logic [6:0]         pad;
    logic signed [31:0] feature_value;
    logic [3:0]         feature_slot;
    logic signed [31:0] leaf_value;
    logic [7:0]         leaf_class;
    logic [7:0]         right_child;
    logic [7:0]         left_child;
    logic signed [31:0] split_threshold;
    logic [3:0]         split_feature;
    logic               node_is_leaf;
    logic [7:0]         node_index;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] predicted_value;
    logic [7:0]         predicted_class;
  } out_word_t;

  typedef struct packed {
    logic       node_wr;
    logic       feat_wr;
    logic       walk_start;
    logic       walk_step;
    logic [1:0] res_code;
    logic       res_hold;
    logic       out_load;
    logic       out_from_hold;
  } dp_cmd_t;

  typedef struct packed {
    logic node_leaf;
    logic at_limit;
  } dp_sts_t;

endpackage

FILE: rtl/core/dti_ctrl.sv
// dti_ctrl: item sequencing and output handshake for decision tree inference
// depends on dti_pkg; drives dti_datapath through dp_cmd_t
module dti_ctrl import dti_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] action,
  input  logic       tree_loaded,
  input  dp_sts_t    sts,
  input  logic       out_tready,
  output logic       out_tvalid,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_WRITE_NODE:   cmd.node_wr = 1'b1;
            ACT_LOAD_FEATURE: cmd.feat_wr = 1'b1;
            ACT_CLASSIFY: begin
              if (tree_loaded) begin
                cmd.walk_start = 1'b1;
                state_nxt      = S_WALK;
              end else begin
                cmd.res_code = ST_NO_TREE;
                if (slot_free) begin
                  cmd.out_load = 1'b1;
                end else begin
                  cmd.res_hold = 1'b1;
                  state_nxt    = S_EMIT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (sts.node_leaf || sts.at_limit) begin
          cmd.res_code = sts.node_leaf ? ST_OK : ST_DEPTH;
          if (slot_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.res_hold = 1'b1;
            state_nxt    = S_EMIT;
          end
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.out_load      = 1'b1;
          cmd.out_from_hold = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/dti_datapath.sv
// dti_datapath: node memory, feature store, split compare and result registers
// depends on dti_pkg; commanded by dti_ctrl
module dti_datapath import dti_pkg::*; #(
  parameter int NODE_COUNT    = 256,
  parameter int FEATURE_COUNT = 16,
  parameter int DEPTH_LIMIT   = 8
) (
  input  logic                   clk,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  // node and slot fields are 8 and 4 bits wide, so only that many entries are reachable
  localparam int NODE_DEPTH = (NODE_COUNT < 256) ? NODE_COUNT : 256;
  localparam int NW         = $clog2(NODE_DEPTH);
  localparam int FEAT_DEPTH = (FEATURE_COUNT < 16) ? FEATURE_COUNT : 16;
  localparam int FW         = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
  localparam int FEAT_SLOTS = 1 << FW;
  localparam int MW         = $clog2(DEPTH_LIMIT + 1);

  typedef logic [NW-1:0] wrap_tab_t [256];

  typedef struct packed {
    logic               leaf;
    logic [3:0]         feature;
    logic signed [31:0] threshold;
    logic [NW-1:0]      left;
    logic [NW-1:0]      right;
    logic [7:0]         cls;
    logic signed [31:0] value;
  } node_t;

  function automatic wrap_tab_t build_wrap();
    wrap_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = NW'(i % NODE_COUNT);
    end
    return t;
  endfunction

  // child index modulo node count, resolved when the node is written
  localparam wrap_tab_t WRAP_TAB = build_wrap();

  in_word_t           in_w;
  node_t              node_mem [NODE_DEPTH];
  node_t              node_r;
  node_t              wr_entry;
  logic signed [31:0] feat_mem [FEAT_SLOTS];
  logic [NW-1:0]      rd_addr;
  logic signed [31:0] feat_x;
  logic               go_left;
  logic [MW-1:0]      moves_r;
  logic [7:0]         res_class, hold_class_r, out_class_r;
  logic signed [31:0] res_value, hold_value_r, out_value_r;
  logic [1:0]         hold_code_r, out_code_r;
  out_word_t          out_w;

  assign in_w = in_word_t'(in_tdata);

  always_comb begin
    wr_entry.leaf      = in_w.node_is_leaf;
    wr_entry.feature   = in_w.split_feature;
    wr_entry.threshold = in_w.split_threshold;
    wr_entry.left      = WRAP_TAB[in_w.left_child];
    wr_entry.right     = WRAP_TAB[in_w.right_child];
    wr_entry.cls       = in_w.leaf_class;
    wr_entry.value     = in_w.leaf_value;
  end

  // features past the store compare as zero
  always_comb begin
    if (32'(node_r.feature) < FEATURE_COUNT) begin
      feat_x = feat_mem[node_r.feature[FW-1:0]];
    end else begin
      feat_x = '0;
    end
  end

  assign go_left = (feat_x <= node_r.threshold);
  assign rd_addr = cmd.walk_step ? (go_left ? node_r.left : node_r.right) : '0;

  assign sts.node_leaf = node_r.leaf;
  assign sts.at_limit  = (moves_r == MW'(DEPTH_LIMIT));

  always_ff @(posedge clk) begin
    if (cmd.node_wr && (32'(in_w.node_index) < NODE_COUNT)) begin
      node_mem[in_w.node_index[NW-1:0]] <= wr_entry;
    end
    node_r <= node_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.feat_wr && (32'(in_w.feature_slot) < FEATURE_COUNT)) begin
      feat_mem[in_w.feature_slot[FW-1:0]] <= in_w.feature_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      moves_r <= '0;
    end else if (cmd.walk_step) begin
      moves_r <= moves_r + MW'(1);
    end
  end

  assign res_class = (cmd.res_code == ST_OK) ? node_r.cls : '0;
  assign res_value = (cmd.res_code == ST_OK) ? node_r.value : '0;

  always_ff @(posedge clk) begin
    if (cmd.res_hold) begin
      hold_class_r <= res_class;
      hold_value_r <= res_value;
      hold_code_r  <= cmd.res_code;
    end
    if (cmd.out_load) begin
      out_class_r <= cmd.out_from_hold ? hold_class_r : res_class;
      out_value_r <= cmd.out_from_hold ? hold_value_r : res_value;
      out_code_r  <= cmd.out_from_hold ? hold_code_r : cmd.res_code;
    end
  end

  assign out_w.predicted_class = out_class_r;
  assign out_w.predicted_value = out_value_r;
  assign out_tdata             = out_w;
  assign out_tuser             = out_code_r;

endmodule

FILE: rtl/core/decision_tree_inference.sv
// decision_tree_inference: top level of the binary decision tree evaluator
// depends on dti_pkg, dti_ctrl and dti_datapath
//
//  channel | direction | handshake             | payload
//  in_     | slave     | in_tvalid / in_tready | in_tuser item kind, in_tdata node or feature
//  out_    | master    | out_tvalid/out_tready | out_tuser status, out_tdata class and value
//  cfg_    | write     | cfg_wr_en             | cfg_wr_data tree_loaded
//
// write-node and load-feature words are handled without leaving the idle state
// a classify word walks the tree from node 0, visiting 1 .. DEPTH_LIMIT + 1 nodes;
// the node memory's registered read sets one level per cycle
// with no tree loaded a classify word returns ST_NO_TREE without a walk
// no word is taken during a walk or while a finished result waits for the output register
// reset clears the controller, the output valid flag and tree_loaded; tables are not cleared
module decision_tree_inference import dti_pkg::*; #(
  parameter int NODE_COUNT    = 256,
  parameter int FEATURE_COUNT = 16,
  parameter int DEPTH_LIMIT   = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // from bit 0: node_index[7:0], node_is_leaf, split_feature[3:0], split_threshold[31:0],
  // left_child[7:0], right_child[7:0], leaf_class[7:0], leaf_value[31:0],
  // feature_slot[3:0], feature_value[31:0], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // from bit 0: predicted_class[7:0], predicted_value[31:0]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data
);

  logic    tree_loaded_r;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // single configuration register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_loaded_r <= 1'b0;
    end else if (cfg_wr_en) begin
      tree_loaded_r <= cfg_wr_data;
    end
  end

  dti_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .action      (in_tuser),
    .tree_loaded (tree_loaded_r),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .cmd         (cmd)
  );

  dti_datapath #(
    .NODE_COUNT    (NODE_COUNT),
    .FEATURE_COUNT (FEATURE_COUNT),
    .DEPTH_LIMIT   (DEPTH_LIMIT)
  ) u_datapath (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
